FILE: sv/rdbf_pkg.sv
// ----------------------------------------------------------------------------
// rdbf_pkg
// shared types and constants of the frame decoder
// ----------------------------------------------------------------------------
package rdbf_pkg;

   localparam int FRAME_WIDTH_DEF  = 80;
   localparam int FRAME_HEIGHT_DEF = 64;

   // sized for the largest frame the parameters allow
   localparam int POS_W   = 17;
   localparam int RADDR_W = 10;

   localparam logic [2:0] KIND_BLANK = 3'd0;
   localparam logic [2:0] KIND_RAW   = 3'd1;
   localparam logic [2:0] KIND_RUN   = 3'd2;
   localparam logic [2:0] KIND_DELTA = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;
   localparam logic [2:0] KIND_FILL  = 3'd5;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_READ  = 3'd1,
      OP_WRITE = 3'd2,
      OP_SWEEP = 3'd3,
      OP_RUN   = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RDWAIT = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_RMW_RD = 5'b01000,
      ST_RMW_WR = 5'b10000
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   pos;
      logic [6:0]         count;
      logic [7:0]         value;
      logic               color;
      logic               invert;
      logic [RADDR_W-1:0] raddr;
      logic               done;
      logic [2:0]         kind;
      logic               over;
   } cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       done;
      logic [2:0] kind;
      logic       over;
   } rsp_type;

   function automatic rsp_type make_rsp(cmd_type c, logic [7:0] d);
      rsp_type r;
      r.read_data = d;
      r.done      = c.done;
      r.kind      = c.kind;
      r.over      = c.over;
      return r;
   endfunction

endpackage

FILE: sv/rdbf_front.sv
// ----------------------------------------------------------------------------
// rdbf_front
// accepts requests, tracks frame position and kind, issues store commands
// ----------------------------------------------------------------------------
module rdbf_front #(
   parameter int FRAME_WIDTH  = rdbf_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = rdbf_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_ready,
   input  logic                        mode,
   input  logic [7:0]                  data_byte,
   input  logic [rdbf_pkg::RADDR_W-1:0] read_address,
   output logic                        cmd_push,
   output rdbf_pkg::cmd_type           cmd
);

   localparam int TOTAL = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int STORE = (TOTAL + 7) / 8;
   localparam logic [rdbf_pkg::POS_W-1:0] TOTAL_P = rdbf_pkg::POS_W'(TOTAL);

   logic [rdbf_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       in_frame_ff, in_frame_in;
   logic [2:0]                 kind_ff, kind_in;
   logic [rdbf_pkg::POS_W-1:0] remain, pos_next;
   logic [6:0]                 count;
   logic [2:0]                 hdr_kind;

   assign cmd_push = in_valid && in_ready;

   always_comb begin
      pos_in      = pos_ff;
      in_frame_in = in_frame_ff;
      kind_in     = kind_ff;
      cmd         = '0;
      cmd.op      = rdbf_pkg::OP_NOP;
      cmd.raddr   = read_address;
      cmd.value   = data_byte;
      cmd.color   = data_byte[0];
      cmd.invert  = (kind_ff == rdbf_pkg::KIND_DELTA);
      cmd.pos     = pos_ff;
      cmd.kind    = kind_ff;
      hdr_kind    = (data_byte <= 8'd5) ? data_byte[2:0] : rdbf_pkg::KIND_BLANK;
      remain      = TOTAL_P - pos_ff;
      count       = data_byte[7:1];
      pos_next    = pos_ff;
      if (mode) begin
         if (32'(read_address) < STORE) begin
            cmd.op = rdbf_pkg::OP_READ;
         end
      end else if (!in_frame_ff) begin
         kind_in  = hdr_kind;
         cmd.kind = hdr_kind;
         case (hdr_kind)
            rdbf_pkg::KIND_RAW, rdbf_pkg::KIND_RUN, rdbf_pkg::KIND_DELTA: begin
               pos_in      = '0;
               in_frame_in = 1'b1;
            end
            rdbf_pkg::KIND_CLEAR: begin
               cmd.op    = rdbf_pkg::OP_SWEEP;
               cmd.value = 8'h00;
               cmd.done  = 1'b1;
            end
            rdbf_pkg::KIND_FILL: begin
               cmd.op    = rdbf_pkg::OP_SWEEP;
               cmd.value = 8'hFF;
               cmd.done  = 1'b1;
            end
            default: begin
               cmd.done = 1'b1;
            end
         endcase
      end else if (kind_ff == rdbf_pkg::KIND_RAW) begin
         cmd.op   = rdbf_pkg::OP_WRITE;
         pos_next = pos_ff + rdbf_pkg::POS_W'(8);
         pos_in   = pos_next;
         if (pos_next >= TOTAL_P) begin
            pos_in      = TOTAL_P;
            in_frame_in = 1'b0;
            cmd.done    = 1'b1;
         end
      end else begin
         if (rdbf_pkg::POS_W'(count) > remain) begin
            count    = remain[6:0];
            cmd.over = 1'b1;
         end
         cmd.count = count;
         if (count != 7'd0 && !(cmd.invert && !cmd.color)) begin
            cmd.op = rdbf_pkg::OP_RUN;
         end
         pos_next = pos_ff + rdbf_pkg::POS_W'(count);
         pos_in   = pos_next;
         if (pos_next >= TOTAL_P) begin
            in_frame_in = 1'b0;
            cmd.done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         in_frame_ff <= 1'b0;
         kind_ff     <= rdbf_pkg::KIND_BLANK;
      end else if (cmd_push) begin
         pos_ff      <= pos_in;
         in_frame_ff <= in_frame_in;
         kind_ff     <= kind_in;
      end
   end

endmodule

FILE: sv/rdbf_queue.sv
// ----------------------------------------------------------------------------
// rdbf_queue
// four-entry command queue between front and back
// ----------------------------------------------------------------------------
module rdbf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rdbf_pkg::cmd_type push_cmd,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output rdbf_pkg::cmd_type head
);

   rdbf_pkg::cmd_type entry_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign not_full  = (cnt_ff != 3'd4);
   assign not_empty = (cnt_ff != 3'd0);
   assign head      = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 2'd1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + {2'b0, push} - {2'b0, pop};
      end
   end

endmodule

FILE: sv/rdbf_back.sv
// ----------------------------------------------------------------------------
// rdbf_back
// frame store and its sequencer: reads, byte writes, sweeps, pixel runs
// ----------------------------------------------------------------------------
module rdbf_back #(
   parameter int FRAME_WIDTH  = rdbf_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = rdbf_pkg::FRAME_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  rdbf_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              init_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rdbf_pkg::rsp_type rsp
);

   localparam int TOTAL = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int STORE = (TOTAL + 7) / 8;
   localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
   localparam logic [AW-1:0] LAST = AW'(STORE - 1);

   logic [7:0] mem [STORE];
   logic [7:0] rd_data_ff;

   rdbf_pkg::state_type state_ff, state_in;
   rdbf_pkg::cmd_type   cur_ff, cur_in;
   rdbf_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                init_ff, init_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;
   logic [2:0]    offs;
   logic [3:0]    room, step;
   logic [7:0]    mask;

   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      offs = cur_ff.pos[2:0];
      room = 4'd8 - {1'b0, offs};
      step = (cur_ff.count < {3'b0, room}) ? cur_ff.count[3:0] : room;
      mask = (8'hFF >> offs) & ~(8'hFF >> ({1'b0, offs} + step));
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      idx_in       = idx_ff;
      init_in      = init_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = AW'(cur_ff.pos >> 3);
      mem_ra       = AW'(cur_ff.pos >> 3);
      mem_wd       = cur_ff.value;
      case (state_ff)
         rdbf_pkg::ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               case (q_head.op)
                  rdbf_pkg::OP_READ: begin
                     mem_re   = 1'b1;
                     mem_ra   = AW'(q_head.raddr);
                     state_in = rdbf_pkg::ST_RDWAIT;
                  end
                  rdbf_pkg::OP_WRITE: begin
                     mem_we       = 1'b1;
                     mem_wa       = AW'(q_head.pos >> 3);
                     mem_wd       = q_head.value;
                     rsp_in       = rdbf_pkg::make_rsp(q_head, 8'h00);
                     rsp_valid_in = 1'b1;
                  end
                  rdbf_pkg::OP_SWEEP: begin
                     idx_in   = '0;
                     state_in = rdbf_pkg::ST_SWEEP;
                  end
                  rdbf_pkg::OP_RUN: begin
                     state_in = rdbf_pkg::ST_RMW_RD;
                  end
                  default: begin
                     rsp_in       = rdbf_pkg::make_rsp(q_head, 8'h00);
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         rdbf_pkg::ST_RDWAIT: begin
            rsp_in       = rdbf_pkg::make_rsp(cur_ff, rd_data_ff);
            rsp_valid_in = 1'b1;
            state_in     = rdbf_pkg::ST_IDLE;
         end
         rdbf_pkg::ST_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = init_ff ? 8'h00 : cur_ff.value;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST) begin
               state_in = rdbf_pkg::ST_IDLE;
               if (init_ff) begin
                  init_in = 1'b0;
               end else begin
                  rsp_in       = rdbf_pkg::make_rsp(cur_ff, 8'h00);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         rdbf_pkg::ST_RMW_RD: begin
            mem_re   = 1'b1;
            state_in = rdbf_pkg::ST_RMW_WR;
         end
         rdbf_pkg::ST_RMW_WR: begin
            mem_we = 1'b1;
            if (cur_ff.invert) begin
               mem_wd = rd_data_ff ^ mask;
            end else if (cur_ff.color) begin
               mem_wd = rd_data_ff | mask;
            end else begin
               mem_wd = rd_data_ff & ~mask;
            end
            cur_in.pos   = cur_ff.pos + rdbf_pkg::POS_W'(step);
            cur_in.count = cur_ff.count - {3'b0, step};
            if (cur_ff.count == {3'b0, step}) begin
               rsp_in       = rdbf_pkg::make_rsp(cur_ff, 8'h00);
               rsp_valid_in = 1'b1;
               state_in     = rdbf_pkg::ST_IDLE;
            end else begin
               state_in = rdbf_pkg::ST_RMW_RD;
            end
         end
         default: begin
            state_in = rdbf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= rdbf_pkg::ST_SWEEP;
         idx_ff       <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/rle_delta_bitmap_frame_decoder.sv
// ----------------------------------------------------------------------------
// rle_delta_bitmap_frame_decoder
// run-length / xor-delta video stream decoder into a 1 bpp frame store
// ----------------------------------------------------------------------------
// req_ carries one stream byte (req_mode 0) or a store read (req_mode 1);
// rsp_ returns exactly one response per request, in request order.
// the front tracks frame kind and pixel position and queues store commands
// (four deep), so it keeps taking requests while the store is busy.
// the store sequencer has one memory port; a raw byte write or a no-op is
// answered straight from idle, a read passes through ST_RDWAIT, a run does a
// read and a write (ST_RMW_RD, ST_RMW_WR) for each store byte touched (up to
// 17 bytes) and a clear or fill sweeps the whole store.
// the next command leaves the queue the cycle after a response is taken, so
// the sequencer works on one command at a time and the worst run sets the
// request rate.
// after reset the store is swept to zero, one byte per cycle (all 640 bytes
// at 80x64); req_ready stays low until the sweep ends.
// a stalled rsp_ready holds the response register; the queue fills and
// req_ready then drops.
// ----------------------------------------------------------------------------
module rle_delta_bitmap_frame_decoder #(
   parameter int FRAME_WIDTH  = rdbf_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = rdbf_pkg::FRAME_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   input  logic [9:0] req_read_address,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_frame_done,
   output logic [2:0] rsp_frame_kind,
   output logic       rsp_overrun
);

   rdbf_pkg::cmd_type push_cmd, head;
   rdbf_pkg::rsp_type rsp;
   logic push, not_full, not_empty, pop, init_busy;

   assign req_ready      = not_full && !init_busy;
   assign rsp_read_data  = rsp.read_data;
   assign rsp_frame_done = rsp.done;
   assign rsp_frame_kind = rsp.kind;
   assign rsp_overrun    = rsp.over;

   rdbf_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .mode         (req_mode),
      .data_byte    (req_data_byte),
      .read_address (req_read_address),
      .cmd_push     (push),
      .cmd          (push_cmd)
   );

   rdbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   rdbf_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (not_empty),
      .q_head    (head),
      .q_pop     (pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule
